### rtl/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Types, constants and the segment decode shared by the thermometer scan
// unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned TempW    = 9;
  localparam int unsigned DwellW   = 16;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // degrees = floor(code * 330 / 1024) - 50
  localparam int unsigned ScaleMul   = 330;
  localparam int unsigned ScaleShift = 10;
  localparam int unsigned TempOffset = 50;

  // r / 10 == (r * 205) >> 11 for r < 100
  localparam int unsigned Div10Mul   = 205;
  localparam int unsigned Div10Shift = 11;

  localparam logic [DwellW-1:0] DwellReset = 16'd10;

  // register index, taken from paddr[2]
  localparam logic REG_DWELL = 1'b0;

  // scan positions
  localparam logic [1:0] DIG_ONES = 2'd0;
  localparam logic [1:0] DIG_TENS = 2'd1;
  localparam logic [1:0] DIG_HUND = 2'd2;

  localparam logic [2:0] EN_ONES = 3'b001;
  localparam logic [2:0] EN_TENS = 3'b010;
  localparam logic [2:0] EN_HUND = 3'b100;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [SampleW-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [7:0]       segments;
    logic [2:0]       digit_enable;
    logic [TempW-1:0] temperature;
  } out_rsp_t;

  typedef struct packed {
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/ats_apb_regs.sv
// ----------------------------------------------------------------------------
// ats_apb_regs
// APB register file holding the per-digit dwell time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_apb_regs
  import ats_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output logic      [DwellW-1:0]   dwell_ticks_o
);

  logic [DwellW-1:0] dwell_q;
  logic              wr_dwell;

  assign wr_dwell = psel && penable && pwrite && (paddr[2] == REG_DWELL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q <= DwellReset;
    end else if (wr_dwell) begin
      dwell_q <= pwdata[DwellW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DWELL) begin
      prdata = ApbDataW'(dwell_q);
    end
  end

  assign pready        = 1'b1;
  assign dwell_ticks_o = dwell_q;

endmodule

`default_nettype wire

### rtl/ats_conv.sv
// ----------------------------------------------------------------------------
// ats_conv
// ADC code to whole degrees, clamped at zero, split into decimal digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_conv
  import ats_pkg::*;
(
  input  wire logic [SampleW-1:0] sample_i,
  output digits_t                 digits_o,
  output logic      [TempW-1:0]   temp_o
);

  localparam int unsigned ProdW = SampleW + TempW;

  logic [ProdW-1:0] prod;
  logic [TempW-1:0] scaled;
  logic [TempW-1:0] temp;
  logic [1:0]       hund;
  logic [TempW-1:0] rem9;
  logic [6:0]       rem;
  logic [14:0]      tmul;
  logic [3:0]       tens;
  logic [6:0]       ones7;

  always_comb begin
    prod   = ProdW'(sample_i) * ProdW'(ScaleMul);
    scaled = prod[ScaleShift +: TempW];
    temp   = (scaled >= TempW'(TempOffset)) ? scaled - TempW'(TempOffset) : '0;
    if (temp >= TempW'(200)) begin
      hund = 2'd2;
      rem9 = temp - TempW'(200);
    end else if (temp >= TempW'(100)) begin
      hund = 2'd1;
      rem9 = temp - TempW'(100);
    end else begin
      hund = 2'd0;
      rem9 = temp;
    end
    rem   = rem9[6:0];
    tmul  = 15'(rem) * 15'(Div10Mul);
    tens  = tmul[Div10Shift +: 4];
    ones7 = rem - 7'(tens) * 7'd10;
  end

  assign digits_o.hundreds = hund;
  assign digits_o.tens     = tens;
  assign digits_o.ones     = ones7[3:0];
  assign temp_o            = temp;

endmodule

`default_nettype wire

### rtl/ats_scan.sv
// ----------------------------------------------------------------------------
// ats_scan
// Display state: stored digits, scan position and dwell counter. Forms the
// result for the request being processed from the updated state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_scan
  import ats_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire in_req_t           req_i,
  input  wire logic [DwellW-1:0] dwell_ticks_i,
  output out_rsp_t               rsp_o
);

  digits_t           digits_q, digits_d;
  logic [TempW-1:0]  temp_q, temp_d;
  logic [1:0]        active_q, active_d;
  logic [DwellW-1:0] count_q, count_d;

  digits_t           conv_digits;
  logic [TempW-1:0]  conv_temp;
  logic [DwellW-1:0] limit;
  logic [DwellW:0]   nxt;
  logic              wrap;

  ats_conv u_conv (
    .sample_i (req_i.sample),
    .digits_o (conv_digits),
    .temp_o   (conv_temp)
  );

  always_comb begin
    digits_d = digits_q;
    temp_d   = temp_q;
    active_d = active_q;
    count_d  = count_q;
    limit    = (dwell_ticks_i == '0) ? DwellW'(1) : dwell_ticks_i;
    nxt      = {1'b0, count_q} + (DwellW+1)'(1);
    wrap     = nxt >= {1'b0, limit};
    if (step_i) begin
      if (req_i.kind == KIND_SAMPLE) begin
        digits_d = conv_digits;
        temp_d   = conv_temp;
      end else if (wrap) begin
        count_d = '0;
        case (active_q)
          DIG_ONES: active_d = DIG_TENS;
          DIG_TENS: active_d = DIG_HUND;
          default:  active_d = DIG_ONES;
        endcase
      end else begin
        count_d = nxt[DwellW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      temp_q   <= '0;
      active_q <= DIG_ONES;
      count_q  <= '0;
    end else begin
      digits_q <= digits_d;
      temp_q   <= temp_d;
      active_q <= active_d;
      count_q  <= count_d;
    end
  end

  always_comb begin
    rsp_o.temperature = temp_d;
    case (active_d)
      DIG_TENS: begin
        rsp_o.segments     = seg_of(digits_d.tens);
        rsp_o.digit_enable = EN_TENS;
      end
      DIG_HUND: begin
        rsp_o.segments     = seg_of({2'b00, digits_d.hundreds});
        rsp_o.digit_enable = EN_HUND;
      end
      default: begin
        rsp_o.segments     = seg_of(digits_d.ones);
        rsp_o.digit_enable = EN_ONES;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/adc_thermometer_seven_segment_scan_unit.sv
// ----------------------------------------------------------------------------
// adc_thermometer_seven_segment_scan_unit
// ADC thermometer with a multiplexed three-digit seven-segment scan.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_req_i): one request per tick
//   (kind 0) or ADC sample (kind 1, code in sample).
//   out channel (out_valid_o/out_ready_i/out_rsp_o): one result per
//   request: active-low segment byte, one-hot digit enable, temperature.
//   APB port: register 0 (byte address 0) is dwell_ticks, reset 10.
// Path: a request is held in the input register, its result in the result
//   register. Throughput: one request per cycle while not stalled; the
//   two registers each hold one request, and the scan state updates in
//   the single step between them.
// Reset: digits clear to zero, scan starts on the ones digit, dwell
//   counter at zero, no result pending.
// Stall: while out_ready_i is low the result holds; one more request is
//   taken into the input register, then in_ready_o drops until the
//   result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adc_thermometer_seven_segment_scan_unit
  import ats_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_req_t             in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_rsp_t                 out_rsp_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  logic              in_vld_q;
  in_req_t           in_req_q;
  logic              out_vld_q;
  out_rsp_t          out_rsp_q;
  logic              adv;
  logic              accept;
  out_rsp_t          rsp;
  logic [DwellW-1:0] dwell_ticks;

  ats_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .dwell_ticks_o (dwell_ticks)
  );

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  ats_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .req_i         (in_req_q),
    .dwell_ticks_i (dwell_ticks),
    .rsp_o         (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q <= in_req_i;
    end
    if (adv) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTH
  a_onehot_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $onehot(out_rsp_q.digit_enable))
    else $error("digit enable not one-hot");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_rsp_q.temperature <= TempW'(279)))
    else $error("temperature out of range");

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("processed request produced no result");
`endif

endmodule

`default_nettype wire

### bench/scan_display_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_display_checker
// Follows the request channel, the result channel and the register port,
// keeps its own digits, scan position and dwell count, and compares every
// result with the display it should show, oldest first.
// ----------------------------------------------------------------------------
module scan_display_checker
  import ats_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_req_t             in_req_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_rsp_t            out_rsp_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic                pready_i,
  output int unsigned         pending_o,
  output int unsigned         mismatches_o
);

  localparam logic [79:0] SegRom = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                    8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
  localparam int unsigned CodeScale  = 330;
  localparam int unsigned CodeShift  = 10;
  localparam int unsigned ZeroOffset = 50;
  localparam logic [DwellW-1:0] DwellAtReset = 16'd10;
  localparam logic [ApbAddrW-1:0] DwellAddr = {REG_DWELL, 2'b00};

  out_rsp_t display_q[$];
  logic [3:0] ones_q;
  logic [3:0] tens_q;
  logic [1:0] hund_q;
  logic [1:0] scan_pos;
  logic [DwellW-1:0] dwell_cnt;
  logic [DwellW-1:0] dwell_set;
  int unsigned fails = 0;

  assign mismatches_o = fails;

  function automatic logic [7:0] segment_code(input logic [3:0] digit);
    return (digit < 4'd10) ? SegRom[digit*8 +: 8] : 8'h00;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t ns: display error on %s: got %0h, want %0h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    int unsigned deg;
    if (!rst_ni) begin
      display_q.delete();
      ones_q = '0;
      tens_q = '0;
      hund_q = '0;
      scan_pos = DIG_ONES;
      dwell_cnt = '0;
      dwell_set = DwellAtReset;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (display_q.size() == 0) begin
          report("unrequested result", 32'(out_rsp_i), 0);
        end else begin
          want = display_q.pop_front();
          if (out_rsp_i.segments !== want.segments)
            report("segments", 32'(out_rsp_i.segments), 32'(want.segments));
          if (out_rsp_i.digit_enable !== want.digit_enable)
            report("digit_enable", 32'(out_rsp_i.digit_enable), 32'(want.digit_enable));
          if (out_rsp_i.temperature !== want.temperature)
            report("temperature", 32'(out_rsp_i.temperature), 32'(want.temperature));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == DwellAddr) begin
        dwell_set = pwdata_i[DwellW-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        if (in_req_i.kind == KIND_SAMPLE) begin
          deg = (32'(in_req_i.sample) * CodeScale) >> CodeShift;
          deg = (deg >= ZeroOffset) ? deg - ZeroOffset : 0;
          ones_q = 4'(deg % 10);
          tens_q = 4'((deg / 10) % 10);
          hund_q = 2'(deg / 100);
        end else if ({1'b0, dwell_cnt} + 17'd1 >= {1'b0, dwell_set}) begin
          dwell_cnt = '0;
          scan_pos = (scan_pos >= DIG_HUND) ? DIG_ONES : scan_pos + 2'd1;
        end else begin
          dwell_cnt = dwell_cnt + 16'd1;
        end
        case (scan_pos)
          DIG_TENS: begin
            want.segments = segment_code(tens_q);
            want.digit_enable = EN_TENS;
          end
          DIG_HUND: begin
            want.segments = segment_code({2'b00, hund_q});
            want.digit_enable = EN_HUND;
          end
          default: begin
            want.segments = segment_code(ones_q);
            want.digit_enable = EN_ONES;
          end
        endcase
        want.temperature = TempW'(hund_q * 100 + tens_q * 10 + ones_q);
        display_q.push_back(want);
      end
      pending_o <= display_q.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks and ADC samples into the thermometer scan unit under random
// idling and stalls, changes the dwell register between phases, and gives
// the verdict from the display checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
  import ats_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned Phases        = 12;
  localparam int unsigned PhaseItems    = 152;
  localparam logic [ApbAddrW-1:0] DwellAddr = {REG_DWELL, 2'b00};

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  in_req_t             in_req    = '0;
  logic                out_ready = 1'b0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ApbAddrW-1:0] paddr     = '0;
  logic [ApbDataW-1:0] pwdata    = '0;
  logic                in_ready;
  logic                out_valid;
  out_rsp_t            out_rsp;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int unsigned         pending;
  int unsigned         mismatches;

  bit          idle_on = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned requests = 0;
  int unsigned results = 0;
  int unsigned ticks = 0;
  int unsigned samples = 0;
  int unsigned dwell_writes = 0;

  adc_thermometer_seven_segment_scan_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  scan_display_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid && in_ready) requests++;
    if (out_valid && out_ready) results++;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: %0d cycles without a handshake", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_request(input logic req_kind, input logic [SampleW-1:0] code);
    in_req_t req;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req.kind = req_kind;
    req.sample = code;
    in_valid <= 1'b1;
    in_req <= req;
    if (req_kind == KIND_TICK) ticks++;
    else samples++;
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_dwell(input logic [DwellW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DwellAddr;
    pwdata <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dwell_writes++;
  endtask

  // hold requests until every expected result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    logic [SampleW-1:0] code;
    logic [DwellW-1:0]  dwell;
    logic               req_kind;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // low codes, the zero boundary, full scale, then scan through all digits
    write_dwell(16'd1);
    send_request(KIND_SAMPLE, 10'd0);
    send_request(KIND_SAMPLE, 10'd155);
    send_request(KIND_SAMPLE, 10'd156);
    send_request(KIND_SAMPLE, 10'd1023);
    repeat (4) send_request(KIND_TICK, 10'h3FF);
    send_request(KIND_SAMPLE, 10'h2AA);
    send_request(KIND_TICK, 10'h155);
    send_request(KIND_SAMPLE, 10'h155);
    send_request(KIND_TICK, 10'h2AA);
    send_request(KIND_SAMPLE, 10'd160);
    // zero dwell behaves as one
    drain();
    write_dwell(16'd0);
    repeat (3) send_request(KIND_TICK, 10'd0);
    // build up a count, then drop the dwell below it
    drain();
    write_dwell(16'hFFFF);
    repeat (6) send_request(KIND_TICK, 10'd0);
    drain();
    write_dwell(16'd3);
    repeat (2) send_request(KIND_TICK, 10'd0);

    for (int p = 0; p < Phases; p++) begin
      drain();
      case (p % 6)
        0:       dwell = 16'd1;
        1:       dwell = DwellW'($urandom_range(2, 6));
        2:       dwell = 16'hFFFF;
        3:       dwell = 16'd0;
        4:       dwell = DwellW'($urandom_range(1, 20));
        default: dwell = DwellW'($urandom_range(7, 400));
      endcase
      if (p == Phases - 1) idle_on = 1'b0;
      write_dwell(dwell);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 3 && i == 20) long_hold = 1'b1;
        if (p == 7 && i == PhaseItems / 2) drain();
        req_kind = ($urandom_range(0, 9) < 7) ? KIND_TICK : KIND_SAMPLE;
        case ($urandom_range(0, 5))
          0:       code = SampleW'($urandom_range(148, 164));
          1:       code = SampleW'($urandom_range(1000, 1023));
          default: code = SampleW'($urandom_range(0, 1023));
        endcase
        send_request(req_kind, code);
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    $display("Covered %0d requests (%0d ticks, %0d samples), %0d results checked,",
             requests, ticks, samples, results);
    $display("%0d dwell writes including 0, 1 and 65535, and one long result stall.",
             dwell_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
